// ----- rtl/cmqe_pkg.sv -----
// Shared types, request and status codes for the CAN message queue engine.
package cmqe_pkg;

  localparam int TX_DEPTH_DEF   = 8;
  localparam int RX_DEPTH_DEF   = 8;
  localparam int MAX_DATA_BYTES = 8;

  localparam int ID_W     = 29;
  localparam int LEN_W    = 4;
  localparam int DATA_W   = 64;
  localparam int IMAGE_W  = 40;
  localparam int RXHDR_W  = 48;
  localparam int COUNT_W  = 4;
  localparam int HDR_W    = ID_W + 2 + LEN_W;
  localparam int ENTRY_W  = DATA_W + HDR_W;

  localparam int IN_TDATA_W  = 152;
  localparam int OUT_TDATA_W = 152;

  localparam logic [1:0] REQ_SEND    = 2'd0;
  localparam logic [1:0] REQ_SERVICE = 2'd1;
  localparam logic [1:0] REQ_RECEIVE = 2'd2;
  localparam logic [1:0] REQ_READ    = 2'd3;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_TX_FULL  = 2'd1;
  localparam logic [1:0] STAT_RX_EMPTY = 2'd2;

  localparam logic [1:0] CHAN_NONE = 2'd3;

  localparam logic [7:0] SIDL_EXIDE = 8'h08;
  localparam logic [7:0] DLC_RTR    = 8'h40;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             remote;
    logic             extended;
    logic [ID_W-1:0]  id;
  } hdr_t;

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
    if (len > LEN_W'(MAX_DATA_BYTES)) begin
      return LEN_W'(MAX_DATA_BYTES);
    end
    return len;
  endfunction

  // Keeps bytes below the clamped length, clears the rest.
  function automatic logic [DATA_W-1:0] mask_payload(input logic [DATA_W-1:0] data,
                                                     input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0]  clen;
    logic [DATA_W-1:0] res;
    clen = clamp_len(len);
    res  = '0;
    for (int i = 0; i < MAX_DATA_BYTES; i++) begin
      if (LEN_W'(i) < clen) begin
        res[8*i +: 8] = data[8*i +: 8];
      end
    end
    return res;
  endfunction

  // SIDH, SIDL, EIDH, EIDL, DLC from high byte to low.
  function automatic logic [IMAGE_W-1:0] build_image(input hdr_t h);
    logic [7:0] sidh, sidl, eidh, eidl, dlc;
    if (h.extended) begin
      sidh = h.id[28:21];
      sidl = {h.id[20:18], 3'b000, h.id[17:16]} | SIDL_EXIDE;
      eidh = h.id[15:8];
      eidl = h.id[7:0];
    end else begin
      sidh = h.id[10:3];
      sidl = {h.id[2:0], 5'b00000};
      eidh = 8'h00;
      eidl = 8'h00;
    end
    dlc = {4'h0, clamp_len(h.len)} | (h.remote ? DLC_RTR : 8'h00);
    return {sidh, sidl, eidh, eidl, dlc};
  endfunction

  // Control, SIDH, SIDL, EIDH, EIDL, DLC from high byte to low.
  function automatic hdr_t unpack_rx(input logic [RXHDR_W-1:0] img);
    hdr_t       h;
    logic [7:0] ctrl, sidh, sidl, eidh, eidl, dlc;
    ctrl = img[47:40];
    sidh = img[39:32];
    sidl = img[31:24];
    eidh = img[23:16];
    eidl = img[15:8];
    dlc  = img[7:0];
    h.extended = sidl[3];
    if (sidl[3]) begin
      h.id = {sidh, sidl[7:5], sidl[1:0], eidh, eidl};
    end else begin
      h.id = {18'd0, sidh, sidl[7:5]};
    end
    h.remote = ctrl[2];
    h.len    = dlc[3:0];
    return h;
  endfunction

endpackage

// ----- rtl/can_message_queue_engine.sv -----
// CAN message queue engine: transmit and receive message rings with register packing.
//
// Each request item is decoded, applied to the rings and answered in the cycle it is
// accepted; its result is loaded into the output register at the accepting edge and can
// be taken from the next edge on. A new item is
// taken every cycle as long as the output register is empty or being drained, so the
// sustained rate is one item per clock. Each ring is a single memory (header and
// payload side by side) whose read port is registered from the next read
// pointer, with a bypass for a write to that same slot, so no ring access adds latency.
// Ring contents are not cleared by reset; only pointers and fill levels are.
module can_message_queue_engine #(
  parameter int TX_DEPTH = cmqe_pkg::TX_DEPTH_DEF,
  parameter int RX_DEPTH = cmqe_pkg::RX_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // msg_identifier, msg_extended, msg_remote, msg_length, msg_data,
  // tx_free_mask, rx_full, rx_header, zero pad
  input  logic [cmqe_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // req_type
  input  logic [1:0]                         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tx_channel, tx_image, data_out, out_identifier, out_extended, out_remote,
  // out_length, tx_count, rx_count, zero pad
  output logic [cmqe_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // status
  output logic [1:0]                         m_axis_tuser
);

  localparam int TXP_W = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam int RXP_W = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int TXC_W = $clog2(TX_DEPTH + 1);
  localparam int RXC_W = $clog2(RX_DEPTH + 1);
  localparam int EW    = cmqe_pkg::ENTRY_W;
  localparam int HW    = cmqe_pkg::HDR_W;

  // input fields
  logic [1:0]                      req;
  logic [cmqe_pkg::ID_W-1:0]       in_id;
  logic                            in_ext;
  logic                            in_rem;
  logic [cmqe_pkg::LEN_W-1:0]      in_len;
  logic [cmqe_pkg::DATA_W-1:0]     in_data;
  logic [2:0]                      in_free;
  logic                            in_rx_full;
  logic [cmqe_pkg::RXHDR_W-1:0]    in_rx_hdr;

  assign req        = s_axis_tuser;
  assign in_id      = s_axis_tdata[28:0];
  assign in_ext     = s_axis_tdata[29];
  assign in_rem     = s_axis_tdata[30];
  assign in_len     = s_axis_tdata[34:31];
  assign in_data    = s_axis_tdata[98:35];
  assign in_free    = s_axis_tdata[101:99];
  assign in_rx_full = s_axis_tdata[102];
  assign in_rx_hdr  = s_axis_tdata[150:103];

  logic accept;
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // ring control
  logic [TXP_W-1:0] tx_wptr, tx_rptr, tx_rptr_next, tx_wptr_next;
  logic [TXC_W-1:0] tx_fill, tx_fill_next;
  logic [RXP_W-1:0] rx_wptr, rx_rptr, rx_rptr_next, rx_wptr_next;
  logic [RXC_W-1:0] rx_fill, rx_fill_next;

  logic tx_we, tx_pop, rx_we, rx_adv, rx_pop;
  logic tx_has_room, rx_has_room;

  assign tx_has_room = tx_fill < TXC_W'(TX_DEPTH);
  assign rx_has_room = rx_fill < RXC_W'(RX_DEPTH);

  assign tx_we  = accept && (req == cmqe_pkg::REQ_SEND) && tx_has_room;
  assign tx_pop = accept && (req == cmqe_pkg::REQ_SERVICE) && (tx_fill != '0) &&
                  (in_free != 3'b000);
  assign rx_we  = accept && (req == cmqe_pkg::REQ_RECEIVE) && in_rx_full;
  assign rx_adv = rx_we && rx_has_room;
  assign rx_pop = accept && (req == cmqe_pkg::REQ_READ) && (rx_fill != '0);

  always_comb begin
    tx_wptr_next = tx_wptr;
    tx_rptr_next = tx_rptr;
    tx_fill_next = tx_fill;
    if (tx_we) begin
      tx_wptr_next = (tx_wptr == TXP_W'(TX_DEPTH - 1)) ? '0 : tx_wptr + 1'b1;
      tx_fill_next = tx_fill + 1'b1;
    end
    if (tx_pop) begin
      tx_rptr_next = (tx_rptr == TXP_W'(TX_DEPTH - 1)) ? '0 : tx_rptr + 1'b1;
      tx_fill_next = tx_fill - 1'b1;
    end
  end

  always_comb begin
    rx_wptr_next = rx_wptr;
    rx_rptr_next = rx_rptr;
    rx_fill_next = rx_fill;
    if (rx_adv) begin
      rx_wptr_next = (rx_wptr == RXP_W'(RX_DEPTH - 1)) ? '0 : rx_wptr + 1'b1;
      rx_fill_next = rx_fill + 1'b1;
    end
    if (rx_pop) begin
      rx_rptr_next = (rx_rptr == RXP_W'(RX_DEPTH - 1)) ? '0 : rx_rptr + 1'b1;
      rx_fill_next = rx_fill - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_wptr <= '0;
      tx_rptr <= '0;
      tx_fill <= '0;
      rx_wptr <= '0;
      rx_rptr <= '0;
      rx_fill <= '0;
    end else begin
      tx_wptr <= tx_wptr_next;
      tx_rptr <= tx_rptr_next;
      tx_fill <= tx_fill_next;
      rx_wptr <= rx_wptr_next;
      rx_rptr <= rx_rptr_next;
      rx_fill <= rx_fill_next;
    end
  end

  // ring memories: entry is {payload, header}
  logic [EW-1:0] tx_mem [TX_DEPTH];
  logic [EW-1:0] rx_mem [RX_DEPTH];
  logic [EW-1:0] tx_wdata, rx_wdata, tx_rd, rx_rd;
  cmqe_pkg::hdr_t tx_new_hdr, rx_new_hdr;

  always_comb begin
    tx_new_hdr.id       = in_id;
    tx_new_hdr.extended = in_ext;
    tx_new_hdr.remote   = in_rem;
    tx_new_hdr.len      = in_len;
  end
  assign rx_new_hdr = cmqe_pkg::unpack_rx(in_rx_hdr);
  assign tx_wdata   = {in_data, tx_new_hdr};
  assign rx_wdata   = {in_data, rx_new_hdr};

  always_ff @(posedge clk) begin
    if (tx_we) begin
      tx_mem[tx_wptr] <= tx_wdata;
    end
    // read ahead at the next head slot, write-first on a collision
    if (tx_we && (tx_wptr == tx_rptr_next)) begin
      tx_rd <= tx_wdata;
    end else begin
      tx_rd <= tx_mem[tx_rptr_next];
    end
  end

  always_ff @(posedge clk) begin
    if (rx_we) begin
      rx_mem[rx_wptr] <= rx_wdata;
    end
    if (rx_we && (rx_wptr == rx_rptr_next)) begin
      rx_rd <= rx_wdata;
    end else begin
      rx_rd <= rx_mem[rx_rptr_next];
    end
  end

  cmqe_pkg::hdr_t tx_head, rx_head;
  assign tx_head = cmqe_pkg::hdr_t'(tx_rd[HW-1:0]);
  assign rx_head = cmqe_pkg::hdr_t'(rx_rd[HW-1:0]);

  // result
  logic [1:0]                       r_status, r_chan;
  logic [cmqe_pkg::IMAGE_W-1:0]     r_image;
  logic [cmqe_pkg::DATA_W-1:0]      r_data;
  logic [cmqe_pkg::ID_W-1:0]        r_id;
  logic                             r_ext, r_rem;
  logic [cmqe_pkg::LEN_W-1:0]       r_len;
  logic [cmqe_pkg::COUNT_W-1:0]     r_txc, r_rxc;
  logic [TXC_W+cmqe_pkg::COUNT_W-1:0] txc_wide;
  logic [RXC_W+cmqe_pkg::COUNT_W-1:0] rxc_wide;

  assign txc_wide = {{cmqe_pkg::COUNT_W{1'b0}}, tx_fill_next};
  assign rxc_wide = {{cmqe_pkg::COUNT_W{1'b0}}, rx_fill_next};
  assign r_txc    = txc_wide[cmqe_pkg::COUNT_W-1:0];
  assign r_rxc    = rxc_wide[cmqe_pkg::COUNT_W-1:0];

  always_comb begin
    r_status = cmqe_pkg::STAT_OK;
    r_chan   = cmqe_pkg::CHAN_NONE;
    r_image  = '0;
    r_data   = '0;
    r_id     = '0;
    r_ext    = 1'b0;
    r_rem    = 1'b0;
    r_len    = '0;
    unique case (req)
      cmqe_pkg::REQ_SEND: begin
        if (!tx_has_room) begin
          r_status = cmqe_pkg::STAT_TX_FULL;
        end
      end
      cmqe_pkg::REQ_SERVICE: begin
        if (tx_pop) begin
          // lowest free buffer wins
          r_chan  = in_free[0] ? 2'd0 : (in_free[1] ? 2'd1 : 2'd2);
          r_image = cmqe_pkg::build_image(tx_head);
          r_data  = cmqe_pkg::mask_payload(tx_rd[EW-1:HW], tx_head.len);
        end
      end
      cmqe_pkg::REQ_RECEIVE: begin
        r_status = cmqe_pkg::STAT_OK;
      end
      cmqe_pkg::REQ_READ: begin
        if (rx_pop) begin
          r_id   = rx_head.id;
          r_ext  = rx_head.extended;
          r_rem  = rx_head.remote;
          r_len  = rx_head.len;
          r_data = cmqe_pkg::mask_payload(rx_rd[EW-1:HW], rx_head.len);
        end else begin
          r_status = cmqe_pkg::STAT_RX_EMPTY;
        end
      end
      default: begin
        r_status = cmqe_pkg::STAT_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_axis_tuser <= r_status;
      m_axis_tdata <= {3'b000, r_rxc, r_txc, r_len, r_rem, r_ext, r_id, r_data,
                       r_image, r_chan};
    end
  end

endmodule

// ----- sim/can_message_queue_engine_tb.sv -----
// Self-checking testbench for the CAN message queue engine: directed table, then random traffic.
module can_message_queue_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TXD = cmqe_pkg::TX_DEPTH_DEF;
  localparam int RXD = cmqe_pkg::RX_DEPTH_DEF;
  localparam int RANDOM_PER_PHASE = 310;
  localparam int HOLD_OFF_CYCLES = 64;

  typedef struct packed {
    logic [1:0]                     kind;
    logic [cmqe_pkg::ID_W-1:0]      id;
    logic                           ext;
    logic                           rem;
    logic [cmqe_pkg::LEN_W-1:0]     len;
    logic [cmqe_pkg::DATA_W-1:0]    data;
    logic [2:0]                     free_mask;
    logic                           rx_full;
    logic [cmqe_pkg::RXHDR_W-1:0]   rx_hdr;
  } request_t;

  typedef struct packed {
    logic [1:0]                     status;
    logic [1:0]                     chan;
    logic [cmqe_pkg::IMAGE_W-1:0]   image;
    logic [cmqe_pkg::DATA_W-1:0]    data;
    logic [cmqe_pkg::ID_W-1:0]      oid;
    logic                           oext;
    logic                           orem;
    logic [cmqe_pkg::LEN_W-1:0]     olen;
    logic [cmqe_pkg::COUNT_W-1:0]   txc;
    logic [cmqe_pkg::COUNT_W-1:0]   rxc;
  } reply_t;

  typedef struct {
    request_t req;
    bit       typed;
    reply_t   want;
  } row_t;

  logic                             clk;
  logic                             rst;
  logic                             s_axis_tvalid;
  logic                             s_axis_tready;
  logic [cmqe_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
  logic [1:0]                       s_axis_tuser;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready;
  logic [cmqe_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic [1:0]                       m_axis_tuser;

  can_message_queue_engine DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Queue state mirror
  cmqe_pkg::hdr_t              tx_ring_hdr[TXD];
  logic [cmqe_pkg::DATA_W-1:0] tx_ring_payload[TXD];
  cmqe_pkg::hdr_t              rx_ring_hdr[RXD];
  logic [cmqe_pkg::DATA_W-1:0] rx_ring_payload[RXD];
  int tx_wp, tx_rp, tx_fill;
  int rx_wp, rx_rp, rx_fill;

  reply_t pending_replies[$];
  row_t   directed_rows[$];
  reply_t seen_reply, due_reply;

  int mismatches;
  int idle_mode;
  int hold_requests, hold_served, hold_left;
  int n_items, n_sends, n_tx_full, n_loads, n_overwrites, n_reads, n_rx_empty;

  initial begin
    clk = 1'b0;
  end

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [cmqe_pkg::DATA_W-1:0] keep_low_bytes(
      input logic [cmqe_pkg::DATA_W-1:0] d, input logic [cmqe_pkg::LEN_W-1:0] len);
    if (len >= cmqe_pkg::LEN_W'(cmqe_pkg::MAX_DATA_BYTES)) begin
      return d;
    end
    return d & ((64'd1 << (8 * len)) - 64'd1);
  endfunction

  function automatic logic [cmqe_pkg::IMAGE_W-1:0] tx_register_image(
      input cmqe_pkg::hdr_t h);
    logic [3:0] n;
    logic [7:0] sidh, sidl, eidh, eidl, dlc;
    n = (h.len > cmqe_pkg::LEN_W'(cmqe_pkg::MAX_DATA_BYTES)) ?
        cmqe_pkg::LEN_W'(cmqe_pkg::MAX_DATA_BYTES) : h.len;
    if (h.extended) begin
      sidh = h.id[28:21];
      sidl = {h.id[20:18], 5'b00000} | cmqe_pkg::SIDL_EXIDE | {6'b000000, h.id[17:16]};
      eidh = h.id[15:8];
      eidl = h.id[7:0];
    end else begin
      // standard frame: upper id bits are ignored
      sidh = h.id[10:3];
      sidl = {h.id[2:0], 5'b00000};
      eidh = 8'h00;
      eidl = 8'h00;
    end
    dlc = {1'b0, h.remote, 2'b00, n};
    return {sidh, sidl, eidh, eidl, dlc};
  endfunction

  function automatic cmqe_pkg::hdr_t rx_header_fields(
      input logic [cmqe_pkg::RXHDR_W-1:0] img);
    cmqe_pkg::hdr_t h;
    h.extended = img[27];
    if (img[27]) begin
      h.id = {img[39:32], img[31:29], img[25:24], img[23:16], img[15:8]};
    end else begin
      h.id = {18'd0, img[39:32], img[31:29]};
    end
    h.remote = img[42];
    h.len    = img[3:0];
    return h;
  endfunction

  task automatic queue_model_step(input request_t q, output reply_t r);
    cmqe_pkg::hdr_t h;
    r = '0;
    r.chan = cmqe_pkg::CHAN_NONE;
    r.status = cmqe_pkg::STAT_OK;
    case (q.kind)
      cmqe_pkg::REQ_SEND: begin
        if (tx_fill < TXD) begin
          h.id = q.id;
          h.extended = q.ext;
          h.remote = q.rem;
          h.len = q.len;
          tx_ring_hdr[tx_wp] = h;
          tx_ring_payload[tx_wp] = q.data;
          tx_wp = (tx_wp + 1) % TXD;
          tx_fill++;
          n_sends++;
        end else begin
          r.status = cmqe_pkg::STAT_TX_FULL;
          n_tx_full++;
        end
      end
      cmqe_pkg::REQ_SERVICE: begin
        if (tx_fill != 0 && q.free_mask != 3'b000) begin
          h = tx_ring_hdr[tx_rp];
          r.chan = q.free_mask[0] ? 2'd0 : (q.free_mask[1] ? 2'd1 : 2'd2);
          r.image = tx_register_image(h);
          r.data = keep_low_bytes(tx_ring_payload[tx_rp], h.len);
          tx_rp = (tx_rp + 1) % TXD;
          tx_fill--;
          n_loads++;
        end
      end
      cmqe_pkg::REQ_RECEIVE: begin
        if (q.rx_full) begin
          rx_ring_hdr[rx_wp] = rx_header_fields(q.rx_hdr);
          rx_ring_payload[rx_wp] = q.data;
          // full ring: the slot at the write pointer, the oldest entry, is overwritten in place
          if (rx_fill < RXD) begin
            rx_wp = (rx_wp + 1) % RXD;
            rx_fill++;
          end else begin
            n_overwrites++;
          end
        end
      end
      default: begin
        if (rx_fill != 0) begin
          h = rx_ring_hdr[rx_rp];
          r.oid = h.id;
          r.oext = h.extended;
          r.orem = h.remote;
          r.olen = h.len;
          r.data = keep_low_bytes(rx_ring_payload[rx_rp], h.len);
          rx_rp = (rx_rp + 1) % RXD;
          rx_fill--;
          n_reads++;
        end else begin
          r.status = cmqe_pkg::STAT_RX_EMPTY;
          n_rx_empty++;
        end
      end
    endcase
    r.txc = cmqe_pkg::COUNT_W'(tx_fill);
    r.rxc = cmqe_pkg::COUNT_W'(rx_fill);
  endtask

  // ---------------------------------------------------------------- stimulus helpers

  function automatic request_t mk_request(input logic [1:0] kind,
                                          input logic [cmqe_pkg::ID_W-1:0] id,
                                          input logic ext, input logic rem,
                                          input logic [cmqe_pkg::LEN_W-1:0] len,
                                          input logic [cmqe_pkg::DATA_W-1:0] d,
                                          input logic [2:0] free_mask, input logic rx_full,
                                          input logic [cmqe_pkg::RXHDR_W-1:0] rx_hdr);
    request_t q;
    q.kind = kind;
    q.id = id;
    q.ext = ext;
    q.rem = rem;
    q.len = len;
    q.data = d;
    q.free_mask = free_mask;
    q.rx_full = rx_full;
    q.rx_hdr = rx_hdr;
    return q;
  endfunction

  function automatic reply_t quiet_reply(input logic [1:0] status, input int txc, input int rxc);
    reply_t r;
    r = '0;
    r.status = status;
    r.chan = cmqe_pkg::CHAN_NONE;
    r.txc = cmqe_pkg::COUNT_W'(txc);
    r.rxc = cmqe_pkg::COUNT_W'(rxc);
    return r;
  endfunction

  // tilt 0 leans toward filling the rings, 1 toward draining, 2 is even
  function automatic request_t random_request(input int tilt);
    request_t q;
    int roll;
    roll = $urandom_range(0, 99);
    q.id = cmqe_pkg::ID_W'($urandom);
    if ($urandom_range(0, 1) == 1) begin
      q.ext = 1'b0;
      if ($urandom_range(0, 3) != 0) begin
        q.id = {18'd0, 11'($urandom)};
      end
    end else begin
      q.ext = 1'b1;
    end
    q.rem = 1'($urandom_range(0, 1));
    q.len = cmqe_pkg::LEN_W'($urandom_range(0, 15));
    q.data = {$urandom, $urandom};
    q.free_mask = ($urandom_range(0, 9) == 0) ? 3'b000 : 3'($urandom_range(1, 7));
    q.rx_full = ($urandom_range(0, 6) != 0);
    q.rx_hdr = {16'($urandom), $urandom};
    case (tilt)
      0: q.kind = (roll < 35) ? cmqe_pkg::REQ_SEND : (roll < 50) ? cmqe_pkg::REQ_SERVICE :
                  (roll < 85) ? cmqe_pkg::REQ_RECEIVE : cmqe_pkg::REQ_READ;
      1: q.kind = (roll < 15) ? cmqe_pkg::REQ_SEND : (roll < 50) ? cmqe_pkg::REQ_SERVICE :
                  (roll < 65) ? cmqe_pkg::REQ_RECEIVE : cmqe_pkg::REQ_READ;
      default: q.kind = (roll < 25) ? cmqe_pkg::REQ_SEND :
                        (roll < 50) ? cmqe_pkg::REQ_SERVICE :
                        (roll < 75) ? cmqe_pkg::REQ_RECEIVE : cmqe_pkg::REQ_READ;
    endcase
    return q;
  endfunction

  task automatic send_request(input request_t q, input bit typed, input reply_t want);
    reply_t r;
    int pct;
    pct = (idle_mode == 0) ? 10 : ((idle_mode == 1) ? 59 : 0);
    while ($urandom_range(0, 99) < pct) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= cmqe_pkg::IN_TDATA_W'({q.rx_hdr, q.rx_full, q.free_mask, q.data,
                                           q.len, q.rem, q.ext, q.id});
    s_axis_tuser <= q.kind;
    do @(posedge clk); while (!s_axis_tready);
    queue_model_step(q, r);
    if (typed) begin
      r = want;
    end
    pending_replies.push_back(r);
    n_items++;
  endtask

  task automatic drain_replies();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_replies.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // ---------------------------------------------------------------- result side

  always @(negedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = HOLD_OFF_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >=
                        ((idle_mode == 0) ? 59 : ((idle_mode == 1) ? 10 : 0)));
    end
  end

  task automatic compare_field(input string label, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, label, want, got);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen_reply.status = m_axis_tuser;
      seen_reply.chan   = m_axis_tdata[1:0];
      seen_reply.image  = m_axis_tdata[41:2];
      seen_reply.data   = m_axis_tdata[105:42];
      seen_reply.oid    = m_axis_tdata[134:106];
      seen_reply.oext   = m_axis_tdata[135];
      seen_reply.orem   = m_axis_tdata[136];
      seen_reply.olen   = m_axis_tdata[140:137];
      seen_reply.txc    = m_axis_tdata[144:141];
      seen_reply.rxc    = m_axis_tdata[148:145];
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result item with nothing expected", $time);
        end
      end else begin
        due_reply = pending_replies.pop_front();
        compare_field("status", 64'(due_reply.status), 64'(seen_reply.status));
        compare_field("tx_channel", 64'(due_reply.chan), 64'(seen_reply.chan));
        compare_field("tx_image", 64'(due_reply.image), 64'(seen_reply.image));
        compare_field("data_out", due_reply.data, seen_reply.data);
        compare_field("out_identifier", 64'(due_reply.oid), 64'(seen_reply.oid));
        compare_field("out_extended", 64'(due_reply.oext), 64'(seen_reply.oext));
        compare_field("out_remote", 64'(due_reply.orem), 64'(seen_reply.orem));
        compare_field("out_length", 64'(due_reply.olen), 64'(seen_reply.olen));
        compare_field("tx_count", 64'(due_reply.txc), 64'(seen_reply.txc));
        compare_field("rx_count", 64'(due_reply.rxc), 64'(seen_reply.rxc));
      end
    end
  end

  // ---------------------------------------------------------------- run control

  initial begin
    #8_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    int tilt;
    row_t row;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = cmqe_pkg::REQ_SEND;
    m_axis_tready = 1'b0;
    idle_mode = 0;
    hold_requests = 0;
    hold_served = 0;
    hold_left = 0;
    mismatches = 0;
    tx_wp = 0; tx_rp = 0; tx_fill = 0;
    rx_wp = 0; rx_rp = 0; rx_fill = 0;
    n_items = 0; n_sends = 0; n_tx_full = 0; n_loads = 0;
    n_overwrites = 0; n_reads = 0; n_rx_empty = 0;

    // empty rings: read, service and no-op receive
    directed_rows.push_back('{mk_request(cmqe_pkg::REQ_READ, '0, 0, 0, 0, '0, 3'b000, 0, '0),
                              1'b1, quiet_reply(cmqe_pkg::STAT_RX_EMPTY, 0, 0)});
    directed_rows.push_back('{mk_request(cmqe_pkg::REQ_SERVICE, '0, 0, 0, 0, '0, 3'b111, 0,
                                         '0),
                              1'b1, quiet_reply(cmqe_pkg::STAT_OK, 0, 0)});
    directed_rows.push_back('{mk_request(cmqe_pkg::REQ_RECEIVE, '1, 1, 1, 15, '1, 3'b111, 0,
                                         '1),
                              1'b1, quiet_reply(cmqe_pkg::STAT_OK, 0, 0)});
    // fill the transmit ring, then send once more into the full ring: extremes of id, length and remote flag
    directed_rows.push_back('{mk_request(cmqe_pkg::REQ_SEND, 29'h7FF, 0, 0, 8, '1, 0, 0, '0),
                              1'b1, quiet_reply(cmqe_pkg::STAT_OK, 1, 0)});
    directed_rows.push_back('{mk_request(cmqe_pkg::REQ_SEND, 29'h1FFFFFFF, 1, 1, 15,
                                         64'h0123_4567_89AB_CDEF, 0, 0, '0),
                              1'b1, quiet_reply(cmqe_pkg::STAT_OK, 2, 0)});
    directed_rows.push_back('{mk_request(cmqe_pkg::REQ_SEND, 29'h1FFFF805, 0, 1, 0, '1, 0, 0,
                                         '0),
                              1'b1, quiet_reply(cmqe_pkg::STAT_OK, 3, 0)});
    directed_rows.push_back('{mk_request(cmqe_pkg::REQ_SEND, 29'h0A5A5A5, 1, 0, 3,
                                         64'hFEDC_BA98_7654_3210, 0, 0, '0),
                              1'b1, quiet_reply(cmqe_pkg::STAT_OK, 4, 0)});
    directed_rows.push_back('{mk_request(cmqe_pkg::REQ_SEND, 29'h0, 0, 0, 1, '1, 0, 0, '0),
                              1'b1, quiet_reply(cmqe_pkg::STAT_OK, 5, 0)});
    directed_rows.push_back('{mk_request(cmqe_pkg::REQ_SEND, 29'h0, 1, 0, 5, '1, 0, 0, '0),
                              1'b1, quiet_reply(cmqe_pkg::STAT_OK, 6, 0)});
    directed_rows.push_back('{mk_request(cmqe_pkg::REQ_SEND, 29'h155, 0, 1, 8,
                                         64'hA5A5_5A5A_A5A5_5A5A, 0, 0, '0),
                              1'b1, quiet_reply(cmqe_pkg::STAT_OK, 7, 0)});
    directed_rows.push_back('{mk_request(cmqe_pkg::REQ_SEND, 29'h1555_5555, 1, 0, 12,
                                         64'h5A5A_A5A5_5A5A_A5A5, 0, 0, '0),
                              1'b1, quiet_reply(cmqe_pkg::STAT_OK, 8, 0)});
    directed_rows.push_back('{mk_request(cmqe_pkg::REQ_SEND, 29'h123, 0, 0, 2, '1, 0, 0, '0),
                              1'b1, quiet_reply(cmqe_pkg::STAT_TX_FULL, 8, 0)});
    // service: no free buffer, then each buffer priority
    directed_rows.push_back('{mk_request(cmqe_pkg::REQ_SERVICE, '0, 0, 0, 0, '0, 3'b000, 0,
                                         '0),
                              1'b1, quiet_reply(cmqe_pkg::STAT_OK, 8, 0)});
    directed_rows.push_back('{mk_request(cmqe_pkg::REQ_SERVICE, '0, 0, 0, 0, '0, 3'b001, 0,
                                         '0), 1'b0, '0});
    directed_rows.push_back('{mk_request(cmqe_pkg::REQ_SERVICE, '0, 0, 0, 0, '0, 3'b010, 0,
                                         '0), 1'b0, '0});
    directed_rows.push_back('{mk_request(cmqe_pkg::REQ_SERVICE, '0, 0, 0, 0, '0, 3'b100, 0,
                                         '0), 1'b0, '0});
    directed_rows.push_back('{mk_request(cmqe_pkg::REQ_SERVICE, '0, 0, 0, 0, '0, 3'b110, 0,
                                         '0), 1'b0, '0});
    directed_rows.push_back('{mk_request(cmqe_pkg::REQ_SERVICE, '0, 0, 0, 0, '0, 3'b111, 0,
                                         '0), 1'b0, '0});
    // receive: standard, extended remote with long length, extended zero length
    directed_rows.push_back('{mk_request(cmqe_pkg::REQ_RECEIVE, '0, 0, 0, 0, '1, 0, 1,
                                         48'h00_FF_E0_00_00_08), 1'b0, '0});
    directed_rows.push_back('{mk_request(cmqe_pkg::REQ_RECEIVE, '0, 0, 0, 0,
                                         64'h1122_3344_5566_7788, 0, 1,
                                         48'h04_A5_EB_5A_C3_0F), 1'b0, '0});
    directed_rows.push_back('{mk_request(cmqe_pkg::REQ_RECEIVE, '0, 0, 0, 0, '1, 0, 1,
                                         48'hFB_00_08_00_00_00), 1'b0, '0});
    directed_rows.push_back('{mk_request(cmqe_pkg::REQ_READ, '0, 0, 0, 0, '0, 0, 0, '0),
                              1'b0, '0});
    directed_rows.push_back('{mk_request(cmqe_pkg::REQ_READ, '0, 0, 0, 0, '0, 0, 0, '0),
                              1'b0, '0});
    directed_rows.push_back('{mk_request(cmqe_pkg::REQ_READ, '0, 0, 0, 0, '0, 0, 0, '0),
                              1'b0, '0});
    directed_rows.push_back('{mk_request(cmqe_pkg::REQ_READ, '0, 0, 0, 0, '0, 0, 0, '0),
                              1'b1, quiet_reply(cmqe_pkg::STAT_RX_EMPTY, 3, 0)});

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_request(row.req, row.typed, row.want);
    end

    tilt = 0;
    for (int phase = 0; phase < 3; phase++) begin
      if (phase > 0) begin
        // sender waits for every result before the idling pattern flips
        drain_replies();
      end
      idle_mode = phase;
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        if (i % 40 == 0) begin
          tilt = $urandom_range(0, 2);
        end
        if (phase == 0 && i == 60) begin
          hold_requests++;
        end
        send_request(random_request(tilt), 1'b0, '0);
      end
    end

    drain_replies();
    repeat (8) @(posedge clk);
    if (pending_replies.size() != 0) begin
      mismatches++;
      $display("%0d results never arrived", pending_replies.size());
    end

    $display("%0d requests: %0d sends queued, %0d dropped on full ring, %0d buffer loads",
             n_items, n_sends, n_tx_full, n_loads);
    $display("%0d receive overwrites, %0d reads, %0d reads of empty ring, %0d mismatches",
             n_overwrites, n_reads, n_rx_empty, mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
